FILE: hw/rtl/fixed_slot_pool_allocator_assert.svh
// Assertion macros for the slot pool allocator checker.
`ifndef FIXED_SLOT_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_SLOT_POOL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define FSPA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FSPA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/fspa_pkg.sv
package fspa_pkg;

   localparam int NUM_SLOTS_DEF = 256;

   localparam int SLOT_W  = 8;
   localparam int COUNT_W = 9;

   localparam logic [COUNT_W-1:0] POOL_SLOTS_RESET = 9'd256;

   localparam logic [1:0] REQ_ALLOC = 2'd0;
   localparam logic [1:0] REQ_FREE  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_NULL  = 2'd3;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [SLOT_W-1:0] slot_index;
      logic              is_null;
   } req_item_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  granted_slot;
      logic [1:0]         status;
      logic               can_allocate;
      logic [COUNT_W-1:0] used_slots;
   } rsp_item_type;

endpackage

FILE: hw/rtl/fixed_slot_pool_allocator.sv
// Fixed-size slot allocator with a free list threaded lazily through the slots.
// req channel (valid/ready): allocate, free or clear; rsp channel (valid/ready):
// one result item per request with granted slot, status, can_allocate and the
// used count after the request. csr_wr_en/csr_wr_data set the pool size.
// Request accepted into an input register, executed from there into the result
// register behind rsp_valid; an allocate may also wait on the link read.
// Throughput: one item per cycle for frees, clears and allocates on an
// unchanged head while the receiver takes results. An allocate right after
// any item that moved the head (or rewrote its link) waits for the registered
// link-memory read of the new head, so successful allocates never run back to back.
// Reset clears head, used count and all slot marks at once and sets the pool
// size to 256; the link memory needs no clearing, an entry is only followed
// while its mark is set. A stalled receiver holds the result register; the
// input register still takes one more item, then req_ready drops.
module fixed_slot_pool_allocator #(
   parameter int NUM_SLOTS = fspa_pkg::NUM_SLOTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  fspa_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output fspa_pkg::rsp_item_type rsp_item,
   input  logic                   csr_wr_en,
   input  logic [8:0]             csr_wr_data
);
   import fspa_pkg::*;

   // only slots below 256 can ever be freed, so storage stops there
   localparam int LINK_DEPTH = (NUM_SLOTS < 256) ? NUM_SLOTS : 256;
   localparam int IDX_W      = $clog2(LINK_DEPTH);
   localparam int CLAMP      = (NUM_SLOTS > 511) ? 511 : NUM_SLOTS;
   localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(LINK_DEPTH);
   localparam logic [COUNT_W-1:0] CLAMP_C = COUNT_W'(CLAMP);

   logic [COUNT_W-1:0]    pool_slots_ff;
   logic                  req_valid_ff;
   req_item_type          req_ff;
   logic                  rsp_valid_ff;
   rsp_item_type          rsp_ff;
   rsp_item_type          rsp_in;
   logic [COUNT_W-1:0]    head_ff, head_in;
   logic [COUNT_W-1:0]    used_ff, used_in;
   logic [LINK_DEPTH-1:0] mark_ff, mark_in;
   logic                  fresh_ff, fresh_in;
   logic [COUNT_W-1:0]    link_rd_ff;
   logic [COUNT_W-1:0]    link_mem [LINK_DEPTH];

   logic [COUNT_W-1:0] lim;
   logic               full;
   logic               mark_hit;
   logic               link_ok;
   logic               exec_fire;
   logic               mem_we;
   logic [IDX_W-1:0]   wr_idx;

   assign lim      = (pool_slots_ff > CLAMP_C) ? CLAMP_C : pool_slots_ff;
   assign full     = (used_ff >= lim);
   assign mark_hit = (head_ff < DEPTH_C) && mark_ff[head_ff[IDX_W-1:0]];
   assign wr_idx   = req_ff.slot_index[IDX_W-1:0];

   // allocate must see the link read for the current head
   assign link_ok   = fresh_ff || (req_ff.req_type != REQ_ALLOC);
   assign exec_fire = req_valid_ff && link_ok && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || exec_fire;

   always_comb begin
      head_in = head_ff;
      used_in = used_ff;
      mark_in = mark_ff;
      mem_we  = 1'b0;
      rsp_in.granted_slot = '0;
      rsp_in.status       = ST_OK;
      if (exec_fire) begin
         unique case (req_ff.req_type)
            REQ_ALLOC: begin
               if (full) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  rsp_in.granted_slot = head_ff[SLOT_W-1:0];
                  head_in = mark_hit ? link_rd_ff : head_ff + 9'd1;
                  used_in = used_ff + 9'd1;
               end
            end
            REQ_FREE: begin
               if (req_ff.is_null) begin
                  rsp_in.status = ST_NULL;
               end else if ({1'b0, req_ff.slot_index} >= lim) begin
                  rsp_in.status = ST_RANGE;
               end else begin
                  mem_we          = 1'b1;
                  mark_in[wr_idx] = 1'b1;
                  head_in         = {1'b0, req_ff.slot_index};
                  if (used_ff != '0) begin
                     used_in = used_ff - 9'd1;
                  end
               end
            end
            REQ_CLEAR: begin
               head_in = '0;
               used_in = '0;
               mark_in = '0;
            end
            default: begin
            end
         endcase
      end
      rsp_in.can_allocate = (used_in < lim);
      rsp_in.used_slots   = used_in;
      fresh_in = !(exec_fire && ((head_in != head_ff) || mem_we));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_slots_ff <= POOL_SLOTS_RESET;
         req_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         head_ff       <= '0;
         used_ff       <= '0;
         mark_ff       <= '0;
         fresh_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            pool_slots_ff <= csr_wr_data;
         end
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (exec_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         head_ff  <= head_in;
         used_ff  <= used_in;
         mark_ff  <= mark_in;
         fresh_ff <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_ff <= req_item;
      end
      if (exec_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // link memory: one write port, one registered read that tracks the head
   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[wr_idx] <= head_ff;
      end
      link_rd_ff <= link_mem[head_ff[IDX_W-1:0]];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

FILE: hw/rtl/fspa_checker.sv
`include "fixed_slot_pool_allocator_assert.svh"

module fspa_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input fspa_pkg::rsp_item_type rsp_item
);
   import fspa_pkg::*;

   `FSPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_item), "result item changed while stalled")
   `FSPA_ASSERT_NOW(a_grant_zero, clock, reset, rsp_valid && (rsp_item.status != ST_OK), rsp_item.granted_slot == '0, "granted slot set on a failed request")
   `FSPA_ASSERT_NOW(a_full_no_alloc, clock, reset, rsp_valid && (rsp_item.status == ST_FULL), !rsp_item.can_allocate, "full status but can_allocate set")
   `FSPA_ASSERT_NOW(a_used_bound, clock, reset, rsp_valid, rsp_item.used_slots <= 9'd256, "used count beyond 256")

endmodule

bind fixed_slot_pool_allocator fspa_checker u_fspa_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

FILE: dv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fspa_pkg::*;

   localparam int           NUM_SLOTS      = NUM_SLOTS_DEF;
   localparam logic [1:0]   REQ_UNUSED     = 2'd3;
   localparam int           WATCHDOG_LIMIT = 2000;
   localparam int           BACKLOG_DEPTH  = 4;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_wr_en = 1'b0;
   logic [8:0]   csr_wr_data = '0;

   fixed_slot_pool_allocator #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // pool state as the block should hold it
   logic [8:0] pool_cfg = POOL_SLOTS_RESET;
   logic [8:0] head_q = '0;
   logic [8:0] used_q = '0;
   logic [8:0] link_mem [NUM_SLOTS];
   bit         link_mark [NUM_SLOTS];

   req_item_type req_backlog [$];
   rsp_item_type owed_results [$];
   logic [7:0]   held_slots [$];

   rsp_item_type want;
   logic         req_taken = 1'b0;
   int           fail_cnt = 0;
   int           rsp_cnt = 0;
   int           n_grant = 0;
   int           n_full = 0;
   int           n_range = 0;
   int           n_null = 0;
   int           n_sizes = 0;
   int           idle_cycles = 0;
   int           send_gap = 0;
   int           burst_left = 0;
   int           stall_tick = 0;
   int           stall_mode = 0;
   int           stall_left = 0;

   function automatic rsp_item_type apply_pool_request(req_item_type it);
      rsp_item_type r;
      int           lim;
      r = '0;
      lim = (pool_cfg > NUM_SLOTS) ? NUM_SLOTS : int'(pool_cfg);
      case (it.req_type)
         REQ_ALLOC: begin
            if (used_q >= lim) begin
               r.status = ST_FULL;
               n_full++;
            end else begin
               r.granted_slot = head_q[7:0];
               // a marked slot jumps along its link, otherwise walk to the next slot
               if (head_q < NUM_SLOTS && link_mark[head_q]) head_q = link_mem[head_q];
               else head_q = head_q + 9'd1;
               used_q = used_q + 9'd1;
               held_slots.push_back(r.granted_slot);
               n_grant++;
            end
         end
         REQ_FREE: begin
            if (it.is_null) begin
               r.status = ST_NULL;
               n_null++;
            end else if (it.slot_index >= lim) begin
               r.status = ST_RANGE;
               n_range++;
            end else begin
               link_mem[it.slot_index] = head_q;
               link_mark[it.slot_index] = 1'b1;
               head_q = {1'b0, it.slot_index};
               if (used_q != 0) used_q = used_q - 9'd1;
               foreach (held_slots[i]) begin
                  if (held_slots[i] == it.slot_index) begin
                     held_slots.delete(i);
                     break;
                  end
               end
            end
         end
         REQ_CLEAR: begin
            head_q = '0;
            used_q = '0;
            foreach (link_mark[i]) link_mark[i] = 1'b0;
            held_slots.delete();
         end
         default: ;
      endcase
      r.can_allocate = (used_q < lim);
      r.used_slots = used_q;
      return r;
   endfunction

   function automatic void check_field(string name, logic [8:0] exp_v, logic [8:0] got_v);
      if (got_v !== exp_v) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
         fail_cnt++;
      end
   endfunction

   // driver: bursts of items with random gaps between them
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0 || req_backlog.size() == 0) begin
            if (send_gap > 0) send_gap--;
            req_valid <= 1'b0;
         end else begin
            req_item <= req_backlog.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 24);
               send_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   // receiver stall pattern, switching at random among four styles
   always @(negedge clock) begin
      stall_tick++;
      if (stall_tick % 50 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= (stall_tick % 3 != 0);
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
               if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
            end
         end
      endcase
   end

   // monitor: predict on request accept, compare on result accept
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) owed_results.push_back(apply_pool_request(req_item));
         if (rsp_valid && rsp_ready) begin
            rsp_cnt++;
            if (owed_results.size() == 0) begin
               $display("%0t: result with nothing expected, got %p", $time, rsp_item);
               fail_cnt++;
            end else begin
               want = owed_results.pop_front();
               check_field("granted_slot", want.granted_slot, rsp_item.granted_slot);
               check_field("status", want.status, rsp_item.status);
               check_field("can_allocate", want.can_allocate, rsp_item.can_allocate);
               check_field("used_slots", want.used_slots, rsp_item.used_slots);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                  $time, WATCHDOG_LIMIT, owed_results.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic push_req(logic [1:0] kind, logic [7:0] slot, logic nul);
      req_item_type it;
      it.req_type = kind;
      it.slot_index = slot;
      it.is_null = nul;
      req_backlog.push_back(it);
   endtask

   task automatic wait_idle();
      while (req_backlog.size() != 0 || req_valid || owed_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_pool_size(logic [8:0] slots);
      wait_idle();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= slots;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      pool_cfg = slots;
      n_sizes++;
   endtask

   // mostly allocates and frees of slots currently held, plus some noise
   task automatic gen_random(int count, int alloc_pct, bit clear_ok);
      int pick;
      for (int k = 0; k < count; k++) begin
         while (req_backlog.size() >= BACKLOG_DEPTH) @(posedge clock);
         pick = $urandom_range(0, 99);
         if (pick < alloc_pct) begin
            push_req(REQ_ALLOC, $urandom_range(0, 255), $urandom_range(0, 1));
         end else begin
            pick = $urandom_range(0, 19);
            if (pick == 0 && clear_ok)
               push_req(REQ_CLEAR, $urandom_range(0, 255), $urandom_range(0, 1));
            else if (pick == 1)
               push_req(REQ_UNUSED, $urandom_range(0, 255), $urandom_range(0, 1));
            else if (pick == 2)
               push_req(REQ_FREE, $urandom_range(0, 255), 1'b1);
            else if (pick <= 4 || held_slots.size() == 0)
               push_req(REQ_FREE, $urandom_range(0, 255), 1'b0);
            else
               push_req(REQ_FREE, held_slots[$urandom_range(0, held_slots.size() - 1)], 1'b0);
         end
      end
   endtask

   initial begin
      foreach (link_mark[i]) link_mark[i] = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_pool_size(9'd256);
      push_req(REQ_ALLOC, 8'd0, 1'b0);
      push_req(REQ_ALLOC, 8'd255, 1'b1);
      push_req(REQ_ALLOC, 8'd0, 1'b0);
      push_req(REQ_FREE, 8'd1, 1'b0);
      push_req(REQ_FREE, 8'd1, 1'b0);      // double free
      push_req(REQ_ALLOC, 8'd0, 1'b0);
      push_req(REQ_CLEAR, 8'd0, 1'b0);
      push_req(REQ_FREE, 8'd255, 1'b0);    // free with nothing used
      push_req(REQ_FREE, 8'd0, 1'b1);
      push_req(REQ_UNUSED, 8'd255, 1'b1);
      push_req(REQ_ALLOC, 8'd0, 1'b0);
      push_req(REQ_ALLOC, 8'd0, 1'b0);
      push_req(REQ_CLEAR, 8'd255, 1'b1);

      write_pool_size(9'd1);
      push_req(REQ_ALLOC, 8'd0, 1'b0);
      push_req(REQ_ALLOC, 8'd0, 1'b0);     // full
      push_req(REQ_FREE, 8'd1, 1'b0);      // out of range
      push_req(REQ_FREE, 8'd255, 1'b1);    // null wins over range
      push_req(REQ_FREE, 8'd0, 1'b0);
      push_req(REQ_ALLOC, 8'd0, 1'b0);

      write_pool_size(9'd0);               // empty pool
      push_req(REQ_ALLOC, 8'd0, 1'b0);
      push_req(REQ_FREE, 8'd0, 1'b0);
      push_req(REQ_CLEAR, 8'd0, 1'b0);

      write_pool_size(9'd511);             // clamps to the slot count
      push_req(REQ_ALLOC, 8'd0, 1'b0);
      push_req(REQ_FREE, 8'd255, 1'b0);
      push_req(REQ_UNUSED, 8'd0, 1'b0);

      write_pool_size(9'd3);
      gen_random(100, 50, 1'b1);
      // long fill run, no clears, so the full pool is reached
      write_pool_size(9'd511);
      push_req(REQ_CLEAR, 8'd0, 1'b0);
      gen_random(330, 93, 1'b0);
      write_pool_size(9'd1);
      gen_random(60, 50, 1'b1);
      write_pool_size(9'd17);
      gen_random(120, 55, 1'b1);
      write_pool_size($urandom_range(0, 511));
      gen_random(90, 55, 1'b1);
      wait_idle();

      $display("Checked %0d results over %0d pool sizes: %0d grants, %0d full,",
               rsp_cnt, n_sizes, n_grant, n_full);
      $display("%0d out-of-range frees, %0d null frees", n_range, n_null);
      if (fail_cnt == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: fixed_slot_pool_allocator.f
+incdir+hw/rtl
hw/rtl/fspa_pkg.sv
hw/rtl/fixed_slot_pool_allocator.sv
hw/rtl/fspa_checker.sv
dv/tb_top.sv
